### src/bfca_pkg.sv
`default_nettype none

package bfca_pkg;

  localparam int unsigned DEF_FREE_SLOTS        = 16;
  localparam int unsigned DEF_ALIGN_BYTES       = 8;
  localparam int unsigned DEF_NODE_HEADER_BYTES = 8;

  localparam logic [31:0] RST_STORE_START = 32'd64;
  localparam logic [31:0] RST_STORE_LIMIT = 32'd1048576;

  localparam logic [15:0] SIZE_CAP = 16'hFFFF;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_LIMIT = 2'd2;

  // register index, taken from paddr[2]
  localparam logic REG_STORE_START = 1'b0;
  localparam logic REG_STORE_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_COMMIT
  } state_t;

  // best-fit token passed down the chain
  typedef struct packed {
    logic        valid;
    logic        found;
    logic [15:0] size;
    logic [31:0] off;
  } tok_t;

  // table update strobes broadcast to every cell
  typedef struct packed {
    logic shift;
    logic append;
  } ctl_t;

endpackage

`default_nettype wire

### src/bfca_cell.sv
`default_nettype none

module bfca_cell import bfca_pkg::*; #(
  parameter int unsigned FREE_SLOTS = DEF_FREE_SLOTS,
  parameter int unsigned POS        = 0,
  localparam int unsigned IW = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1,
  localparam int unsigned CW = $clog2(FREE_SLOTS + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [15:0]   need,
  input  wire logic [CW-1:0] count,
  input  wire logic [IW-1:0] pick,
  input  wire ctl_t          ctl,
  input  wire logic [31:0]   wr_off,
  input  wire logic [15:0]   wr_size,
  input  wire logic [31:0]   nb_off,
  input  wire logic [15:0]   nb_size,
  input  wire tok_t          tok_in,
  input  wire logic [IW-1:0] idx_in,
  output tok_t               tok_out,
  output logic [IW-1:0]      idx_out,
  output logic [31:0]        ent_off,
  output logic [15:0]        ent_size
);

  logic [31:0]   off_r;
  logic [15:0]   size_r;
  tok_t          tok_r;
  tok_t          tok_nxt;
  logic [IW-1:0] idx_r;
  logic [IW-1:0] idx_nxt;
  logic          occupied;
  logic          hit;

  assign occupied = count > CW'(POS);
  // strict less-than keeps the earliest entry on equal sizes
  assign hit = tok_in.valid && occupied && (size_r >= need) && (size_r < tok_in.size);

  always_comb begin
    tok_nxt = tok_in;
    idx_nxt = idx_in;
    if (hit) begin
      tok_nxt.found = 1'b1;
      tok_nxt.size  = size_r;
      tok_nxt.off   = off_r;
      idx_nxt       = IW'(POS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (ctl.shift && (IW'(POS) >= pick)) begin
      off_r  <= nb_off;
      size_r <= nb_size;
    end else if (ctl.append && (count == CW'(POS))) begin
      off_r  <= wr_off;
      size_r <= wr_size;
    end
  end

  assign tok_out  = tok_r;
  assign idx_out  = idx_r;
  assign ent_off  = off_r;
  assign ent_size = size_r;

endmodule

`default_nettype wire

### src/best_fit_chunk_allocator_unit.sv
`default_nettype none
// out_tvalid rises once a commit loads the output register. A free goes from
// acceptance straight to commit; for an allocate the best-fit token walks one cell
// per cycle down the chain, then the winner is latched, the unit commits and the
// output register is loaded. One request is in flight; the next word is taken the
// cycle after commit, and commit waits while an earlier result is still held on the
// output. Reset (synchronous, rst_n low) empties the free table, loads
// store_start/store_limit defaults and sets store_end to 64.

module best_fit_chunk_allocator_unit import bfca_pkg::*; #(
  parameter int unsigned FREE_SLOTS        = DEF_FREE_SLOTS,
  parameter int unsigned ALIGN_BYTES       = DEF_ALIGN_BYTES,
  parameter int unsigned NODE_HEADER_BYTES = DEF_NODE_HEADER_BYTES
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // data_size, free_offset, free_size
  input  wire logic        in_tuser,   // req_type
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // chunk_offset, chunk_size
  output logic [2:0]       out_tuser,  // reused, status
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int unsigned IW = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
  localparam int unsigned CW = $clog2(FREE_SLOTS + 1);
  // reciprocal of the alignment, exact for any 17-bit numerator
  localparam int unsigned AL = $clog2(ALIGN_BYTES);
  localparam int unsigned RS = 17 + AL;
  localparam int unsigned RM = ((1 << RS) + ALIGN_BYTES - 1) / ALIGN_BYTES;

  state_t        state_r, state_nxt;
  logic [31:0]   store_start_r;
  logic [31:0]   store_limit_r;
  logic [31:0]   store_end_r;
  logic [CW-1:0] count_r;

  logic          req_r;
  logic [15:0]   need_r;
  logic [31:0]   foff_r;
  logic [15:0]   fsz_r;
  logic          seed_vld_r;
  logic          scan_done_r;
  logic          best_found_r;
  logic [15:0]   best_size_r;
  logic [31:0]   best_off_r;
  logic [IW-1:0] best_idx_r;
  logic [16:0]   quot_r;
  logic [16:0]   rounded_r;

  logic          out_valid_r;
  logic [31:0]   out_off_r;
  logic [15:0]   out_size_r;
  logic          out_reused_r;
  logic [1:0]    out_status_r;

  logic          fire;
  logic          cfg_wr;
  logic          commit_go;
  logic          full;
  logic [16:0]   round_num;
  logic [35:0]   recip_prod;
  logic [33:0]   new_end;
  logic          carve_ok;
  ctl_t          ctl;

  tok_t          tok_w   [FREE_SLOTS+1];
  logic [IW-1:0] idx_w   [FREE_SLOTS+1];
  logic [31:0]   ent_off [FREE_SLOTS+1];
  logic [15:0]   ent_size[FREE_SLOTS+1];

  // ---------------- cell chain
  assign tok_w[0].valid = seed_vld_r;
  assign tok_w[0].found = 1'b0;
  assign tok_w[0].size  = SIZE_CAP;
  assign tok_w[0].off   = 32'd0;
  assign idx_w[0]       = '0;
  assign ent_off[FREE_SLOTS]  = 32'd0;
  assign ent_size[FREE_SLOTS] = 16'd0;

  assign ctl.shift  = commit_go && (req_r == REQ_ALLOC) && best_found_r;
  assign ctl.append = commit_go && (req_r == REQ_FREE) && !full;

  for (genvar g = 0; g < FREE_SLOTS; g++) begin : g_cell
    bfca_cell #(
      .FREE_SLOTS (FREE_SLOTS),
      .POS        (g)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .need     (need_r),
      .count    (count_r),
      .pick     (best_idx_r),
      .ctl      (ctl),
      .wr_off   (foff_r),
      .wr_size  (fsz_r),
      .nb_off   (ent_off[g+1]),
      .nb_size  (ent_size[g+1]),
      .tok_in   (tok_w[g]),
      .idx_in   (idx_w[g]),
      .tok_out  (tok_w[g+1]),
      .idx_out  (idx_w[g+1]),
      .ent_off  (ent_off[g]),
      .ent_size (ent_size[g])
    );
  end

  // ---------------- control
  assign fire     = in_tvalid && in_tready;
  assign cfg_wr   = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign full     = count_r == CW'(FREE_SLOTS);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (fire) state_nxt = (in_tuser == REQ_FREE) ? S_COMMIT : S_SEARCH;
      end
      S_SEARCH: begin
        if (scan_done_r) state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (commit_go) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    commit_go = 1'b0;
    unique case (state_r)
      S_IDLE:   in_tready = 1'b1;
      S_SEARCH: ;
      S_COMMIT: commit_go = !out_valid_r || out_tready;
      default:  ;
    endcase
  end

  // carve size: quotient by reciprocal multiply, two register stages while the token walks
  assign round_num  = 17'(need_r) + 17'(ALIGN_BYTES - 1);
  assign recip_prod = 36'(round_num) * 36'(RM);
  assign new_end  = 34'(store_end_r) + 34'(rounded_r) + 34'(NODE_HEADER_BYTES);
  assign carve_ok = (rounded_r <= 17'(SIZE_CAP)) && (new_end <= 34'(store_limit_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      seed_vld_r  <= 1'b0;
      scan_done_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      seed_vld_r <= fire && (in_tuser == REQ_ALLOC);
      if (fire) begin
        scan_done_r <= 1'b0;
      end else if (tok_w[FREE_SLOTS].valid) begin
        scan_done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      req_r  <= in_tuser;
      need_r <= in_tdata[15:0];
      foff_r <= in_tdata[47:16];
      fsz_r  <= in_tdata[63:48];
    end
    quot_r    <= 17'(recip_prod >> RS);
    rounded_r <= 17'(30'(quot_r) * 30'(ALIGN_BYTES));
    if (tok_w[FREE_SLOTS].valid) begin
      best_found_r <= tok_w[FREE_SLOTS].found;
      best_size_r  <= tok_w[FREE_SLOTS].size;
      best_off_r   <= tok_w[FREE_SLOTS].off;
      best_idx_r   <= idx_w[FREE_SLOTS];
    end
  end

  // ---------------- state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_start_r <= RST_STORE_START;
      store_limit_r <= RST_STORE_LIMIT;
      store_end_r   <= RST_STORE_START;
      count_r       <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_paddr[2])
          REG_STORE_START: begin
            store_start_r <= cfg_pwdata;
            store_end_r   <= cfg_pwdata;
          end
          REG_STORE_LIMIT: store_limit_r <= cfg_pwdata;
          default: ;
        endcase
      end
      if (ctl.shift)  count_r <= count_r - CW'(1);
      if (ctl.append) count_r <= count_r + CW'(1);
      if (commit_go && (req_r == REQ_ALLOC) && !best_found_r && carve_ok)
        store_end_r <= new_end[31:0];
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_STORE_START: cfg_prdata = store_start_r;
      REG_STORE_LIMIT: cfg_prdata = store_limit_r;
      default:         cfg_prdata = 32'd0;
    endcase
  end
  assign cfg_pready = 1'b1;

  // ---------------- output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit_go) begin
      out_off_r    <= 32'd0;
      out_size_r   <= 16'd0;
      out_reused_r <= 1'b0;
      out_status_r <= ST_OK;
      if (req_r == REQ_FREE) begin
        if (full) out_status_r <= ST_FULL;
      end else if (best_found_r) begin
        out_off_r    <= best_off_r;
        out_size_r   <= best_size_r;
        out_reused_r <= 1'b1;
      end else if (carve_ok) begin
        out_off_r  <= store_end_r;
        out_size_r <= rounded_r[15:0];
      end else begin
        out_status_r <= ST_LIMIT;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_size_r, out_off_r};
  assign out_tuser  = {out_status_r, out_reused_r};

  // ---------------- checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(FREE_SLOTS)) else $error("free count beyond table depth");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (count_r == $past(count_r)) || (count_r == $past(count_r) + CW'(1)) ||
             (count_r + CW'(1) == $past(count_r)))
    else $error("free count jumped");

  a_tail_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    tok_w[FREE_SLOTS].valid |-> (state_r == S_SEARCH))
    else $error("search token left chain outside search");

  a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_COMMIT))
    else $error("result appeared without commit");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_status_r != 2'd3)) else $error("bad status code");

endmodule

`default_nettype wire

### tb/tb_top.sv
`default_nettype none

module tb_top import bfca_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS = DEF_FREE_SLOTS;
  localparam int unsigned ALIGN = DEF_ALIGN_BYTES;
  localparam int unsigned HDR   = DEF_NODE_HEADER_BYTES;
  localparam int unsigned DRAIN_CYCLES = 40;

  typedef struct packed {
    logic        req;
    logic [15:0] dsize;
    logic [31:0] foff;
    logic [15:0] fsize;
  } request_t;

  typedef struct packed {
    logic [31:0] offset;
    logic [15:0] size;
    logic        reused;
    logic [1:0]  status;
  } grant_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;   // data_size, free_offset, free_size
  logic        in_tuser = 1'b0; // req_type
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;       // chunk_offset, chunk_size
  logic [2:0]  out_tuser;       // reused, status
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  best_fit_chunk_allocator_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // allocator shadow state
  logic [31:0] fl_off [SLOTS];
  logic [15:0] fl_size [SLOTS];
  int unsigned fl_count;
  logic [31:0] end_ptr;
  logic [31:0] start_reg;
  logic [31:0] limit_reg;

  request_t requests_todo[$];
  grant_t   grants_due[$];
  int       mismatches = 0;
  bit       quiet = 1'b0;
  int       in_gap = 0;
  int       out_hold = 0;

  function automatic grant_t grant_for(request_t r);
    grant_t      g;
    logic [15:0] best;
    int unsigned pick;
    bit          hit;
    int unsigned i;
    logic [63:0] rounded;
    logic [63:0] new_end;
    g = '0;
    g.status = ST_OK;
    if (r.req == REQ_FREE) begin
      if (fl_count >= SLOTS) begin
        g.status = ST_FULL;
      end else begin
        fl_off[fl_count]  = r.foff;
        fl_size[fl_count] = r.fsize;
        fl_count++;
      end
      return g;
    end
    best = SIZE_CAP;
    pick = 0;
    hit  = 1'b0;
    for (i = 0; i < fl_count; i++) begin
      if (fl_size[i] >= r.dsize && fl_size[i] < best) begin
        best = fl_size[i];
        pick = i;
        hit  = 1'b1;
      end
    end
    if (hit) begin
      g.offset = fl_off[pick];
      g.size   = best;
      g.reused = 1'b1;
      for (i = pick; i + 1 < fl_count; i++) begin
        fl_off[i]  = fl_off[i + 1];
        fl_size[i] = fl_size[i + 1];
      end
      fl_count--;
      return g;
    end
    rounded = ((64'(r.dsize) + 64'(ALIGN - 1)) / 64'(ALIGN)) * 64'(ALIGN);
    new_end = 64'(end_ptr) + rounded + 64'(HDR);
    if (rounded > 64'(SIZE_CAP) || new_end > 64'(limit_reg)) begin
      g.status = ST_LIMIT;
    end else begin
      g.offset = end_ptr;
      g.size   = rounded[15:0];
      end_ptr  = new_end[31:0];
    end
    return g;
  endfunction

  function automatic logic [15:0] pick_size(bit wide);
    logic [15:0] s;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: s = 16'd0;
          1: s = 16'd1;
          2: s = 16'd65528;
          3: s = 16'hFFFE;
          default: s = SIZE_CAP;
        endcase
      end
      1, 2: s = 16'($urandom_range(0, 65535));
      default: s = wide ? 16'($urandom_range(0, 4095)) : 16'($urandom_range(0, 256));
    endcase
    return s;
  endfunction

  function automatic request_t random_request();
    request_t r;
    r.req   = ($urandom_range(0, 99) < 45) ? REQ_FREE : REQ_ALLOC;
    r.dsize = pick_size(1'b0);
    r.foff  = $urandom();
    r.fsize = pick_size(1'b0);
    // most frees carry sizes that later allocations can actually hit
    if (r.req == REQ_FREE && $urandom_range(0, 3) != 0)
      r.fsize = 16'($urandom_range(0, 32) * ALIGN);
    return r;
  endfunction

  task automatic queue_request(logic req, logic [15:0] d, logic [31:0] o, logic [15:0] s);
    request_t r;
    r.req   = req;
    r.dsize = d;
    r.foff  = o;
    r.fsize = s;
    requests_todo.push_back(r);
  endtask

  task automatic reg_write(logic idx, logic [31:0] val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (idx == REG_STORE_START) begin
      start_reg = val;
      end_ptr   = val;
    end else begin
      limit_reg = val;
    end
  endtask

  task automatic reg_check(logic idx);
    logic [31:0] want;
    want = (idx == REG_STORE_START) ? start_reg : limit_reg;
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== want) begin
      $error("prdata[%0d]: expected %h, actual %h", idx, want, cfg_prdata);
      mismatches++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic drain();
    while (requests_todo.size() > 0 || in_tvalid || grants_due.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("** best_fit_chunk_allocator_unit: FAILED **");
    $finish;
  end

  // driver
  always @(posedge clk) begin
    request_t w;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        grants_due.push_back(grant_for({in_tuser, in_tdata[15:0], in_tdata[47:16],
                                        in_tdata[63:48]}));
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (requests_todo.size() > 0) begin
          w = requests_todo.pop_front();
          in_tdata  <= {w.fsize, w.foff, w.dsize};
          in_tuser  <= w.req;
          in_tvalid <= 1'b1;
          if (!quiet && $urandom_range(0, 7) == 0)
            in_gap = $urandom_range(1, 12);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    grant_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (grants_due.size() == 0) begin
          $error("unexpected result word: tdata %h tuser %h", out_tdata, out_tuser);
          mismatches++;
        end else begin
          want = grants_due.pop_front();
          if (out_tdata[31:0] !== want.offset) begin
            $error("chunk_offset: expected %h, actual %h", want.offset, out_tdata[31:0]);
            mismatches++;
          end
          if (out_tdata[47:32] !== want.size) begin
            $error("chunk_size: expected %h, actual %h", want.size, out_tdata[47:32]);
            mismatches++;
          end
          if (out_tuser[0] !== want.reused) begin
            $error("reused: expected %b, actual %b", want.reused, out_tuser[0]);
            mismatches++;
          end
          if (out_tuser[2:1] !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_tuser[2:1]);
            mismatches++;
          end
        end
      end
      if (out_hold > 0) begin
        out_hold--;
        out_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_hold = $urandom_range(0, 11);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    logic [31:0] phase_start [6];
    logic [31:0] phase_limit [6];
    int          phase_items [6];
    int          p;
    int          n;
    phase_start = '{32'd64, 32'd0, 32'hFFFF_FF00, 32'd1000, 32'd500, 32'd128};
    phase_limit = '{32'd1048576, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd4000, 32'd0, 32'd1048576};
    phase_items = '{200, 200, 120, 150, 100, 230};
    fl_count  = 0;
    start_reg = RST_STORE_START;
    limit_reg = RST_STORE_LIMIT;
    end_ptr   = RST_STORE_START;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    reg_check(REG_STORE_START);
    reg_check(REG_STORE_LIMIT);

    // directed part on reset settings
    queue_request(REQ_ALLOC, 16'd0, '0, '0);             // zero-size carve
    queue_request(REQ_ALLOC, 16'd1, '0, '0);
    queue_request(REQ_ALLOC, 16'hFFFF, '0, '0);          // rounds past the size cap
    queue_request(REQ_ALLOC, 16'd65528, '0, '0);         // largest carve
    queue_request(REQ_FREE, 16'hFFFF, 32'hFFFF_FFFF, SIZE_CAP);
    queue_request(REQ_FREE, 16'd0, 32'h0000_0000, 16'd0);
    queue_request(REQ_FREE, 16'd0, 32'h0000_1000, 16'd100);
    queue_request(REQ_FREE, 16'd0, 32'h0000_2000, 16'd100);
    queue_request(REQ_FREE, 16'd0, 32'h0000_3000, 16'd40);
    queue_request(REQ_ALLOC, 16'd50, 32'hFFFF_FFFF, 16'hFFFF); // tie, earliest wins
    queue_request(REQ_ALLOC, 16'd0, '0, '0);             // zero-size chunk reused
    queue_request(REQ_ALLOC, 16'hFFFF, '0, '0);          // full-size chunk never chosen
    queue_request(REQ_ALLOC, 16'd100, 32'hA5A5_A5A5, 16'h5A5A);
    for (n = 0; n < 15; n++)                            // last one finds the table full
      queue_request(REQ_FREE, 16'hFFFF, 32'h8000_0000 + 32'(n * 64), 16'(n * 8 + 8));
    queue_request(REQ_ALLOC, 16'd57, '0, '0);            // removes a middle entry
    drain();

    for (p = 0; p < 6; p++) begin
      reg_write(REG_STORE_START, phase_start[p]);
      reg_write(REG_STORE_LIMIT, phase_limit[p]);
      reg_check(REG_STORE_START);
      reg_check(REG_STORE_LIMIT);
      quiet = (p == 5);
      for (n = 0; n < phase_items[p]; n++)
        requests_todo.push_back(random_request());
      drain();
    end

    if (mismatches == 0 && grants_due.size() == 0) begin
      $display("** best_fit_chunk_allocator_unit: PASSED **");
    end else begin
      $display("** best_fit_chunk_allocator_unit: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
src/bfca_pkg.sv
src/bfca_cell.sv
src/best_fit_chunk_allocator_unit.sv
tb/tb_top.sv
